FILE: hdl/bgtp_pkg.sv
// Shared widths, register codes and the glyph ROM of the bitmap glyph text plotter.
`timescale 1ns / 1ps

package bgtp_pkg;

	// Payload widths of the character, pixel and configuration words
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned POS_W     = 12;
	localparam int unsigned COLOUR_W  = 8;
	localparam int unsigned OFFSET_W  = 22;
	localparam int unsigned DIM_REG_W = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CURSOR_W  = 16;

	// Defaults for the top-level parameters
	localparam int unsigned FRAME_DIM_MAX_DEF = 1024;
	localparam int unsigned GLYPH_ROWS_DEF    = 7;
	localparam int unsigned GLYPH_COLS_DEF    = 4;

	// Register reset values
	localparam int unsigned FRAME_W_RESET = 400;
	localparam int unsigned FRAME_H_RESET = 240;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Character code handling
	localparam logic [CHAR_W-1:0] ASCII_MAX  = 8'd127;
	localparam logic [CHAR_W-1:0] QMARK_CODE = 8'h3F;
	localparam logic [CHAR_W-1:0] CTRL_LIMIT = 8'd32;

	// Font ROM geometry: seven rows of four bits, row 0 in the top nibble
	localparam int unsigned FONT_ROWS = 7;
	localparam int unsigned FONT_COLS = 4;
	localparam int unsigned ADV_W     = 3;
	localparam logic [ADV_W-1:0] CTRL_ADV = 3'd4;

	typedef struct packed {
		logic [FONT_ROWS*FONT_COLS-1:0] rows;
		logic [ADV_W-1:0]               adv;
	} glyph_t;

	// Glyph lookup; control codes are blank with width four, unknown codes blank with width zero.
	function automatic glyph_t font_glyph(input logic [CHAR_W-1:0] code);
		glyph_t g;
		g.rows = '0;
		g.adv  = '0;
		if (code < CTRL_LIMIT) begin
			g.adv = CTRL_ADV;
		end else begin
			case (code)
				" ":  g = '{28'h0000000, 3'd3};
				"!":  g = '{28'h4444040, 3'd4};
				"\"": g = '{28'hAA00000, 3'd4};
				"#":  g = '{28'hAFAFA00, 3'd4};
				"%":  g = '{28'h9249000, 3'd4};
				"(":  g = '{28'h2444200, 3'd3};
				")":  g = '{28'h4222400, 3'd3};
				"+":  g = '{28'h04E4000, 3'd4};
				",":  g = '{28'h0000448, 3'd4};
				"-":  g = '{28'h00E0000, 3'd4};
				".":  g = '{28'h0000400, 3'd4};
				"/":  g = '{28'h1248000, 3'd4};
				"0":  g = '{28'h6999600, 3'd4};
				"1":  g = '{28'h2622700, 3'd4};
				"2":  g = '{28'h6924F00, 3'd4};
				"3":  g = '{28'h6929600, 3'd4};
				"4":  g = '{28'h99F1100, 3'd4};
				"5":  g = '{28'hF8E1E00, 3'd4};
				"6":  g = '{28'h68E9600, 3'd4};
				"7":  g = '{28'hF124400, 3'd4};
				"8":  g = '{28'h6969600, 3'd4};
				"9":  g = '{28'h6971600, 3'd4};
				":":  g = '{28'h0404000, 3'd4};
				"A":  g = '{28'h69F9900, 3'd4};
				"B":  g = '{28'hE9E9E00, 3'd4};
				"C":  g = '{28'h6989600, 3'd4};
				"D":  g = '{28'hE999E00, 3'd4};
				"E":  g = '{28'hF8E8F00, 3'd4};
				"F":  g = '{28'hF8E8800, 3'd4};
				"G":  g = '{28'h78B9700, 3'd4};
				"H":  g = '{28'h99F9900, 3'd4};
				"I":  g = '{28'hE444E00, 3'd4};
				"J":  g = '{28'h1119600, 3'd4};
				"K":  g = '{28'h9ACA900, 3'd4};
				"L":  g = '{28'h8888F00, 3'd4};
				"M":  g = '{28'h9FF9900, 3'd4};
				"N":  g = '{28'h9DB9900, 3'd4};
				"O":  g = '{28'h6999600, 3'd4};
				"P":  g = '{28'hE9E8800, 3'd4};
				"Q":  g = '{28'h699B700, 3'd4};
				"R":  g = '{28'hE9EA900, 3'd4};
				"S":  g = '{28'h7861E00, 3'd4};
				"T":  g = '{28'hE444400, 3'd4};
				"U":  g = '{28'h9999600, 3'd4};
				"V":  g = '{28'h9996600, 3'd4};
				"W":  g = '{28'h99FF900, 3'd4};
				"X":  g = '{28'h9969900, 3'd4};
				"Y":  g = '{28'h9971600, 3'd4};
				"Z":  g = '{28'hF248F00, 3'd4};
				"a":  g = '{28'h0699700, 3'd4};
				"b":  g = '{28'h8E99E00, 3'd4};
				"c":  g = '{28'h0788700, 3'd4};
				"d":  g = '{28'h1799700, 3'd4};
				"e":  g = '{28'h06F8700, 3'd4};
				"f":  g = '{28'h34E4400, 3'd4};
				"g":  g = '{28'h0797160, 3'd4};
				"h":  g = '{28'h8E99900, 3'd4};
				"i":  g = '{28'h4044400, 3'd4};
				"j":  g = '{28'h2022A40, 3'd4};
				"k":  g = '{28'h8ACA900, 3'd4};
				"l":  g = '{28'h4444200, 3'd4};
				"m":  g = '{28'h0FF9900, 3'd4};
				"n":  g = '{28'h0E99900, 3'd4};
				"o":  g = '{28'h0699600, 3'd4};
				"p":  g = '{28'h0E9E880, 3'd4};
				"q":  g = '{28'h0797110, 3'd4};
				"r":  g = '{28'h0BC8800, 3'd4};
				"s":  g = '{28'h07C3E00, 3'd4};
				"t":  g = '{28'h4E44300, 3'd4};
				"u":  g = '{28'h0999700, 3'd4};
				"v":  g = '{28'h0996600, 3'd4};
				"w":  g = '{28'h09FF900, 3'd4};
				"x":  g = '{28'h0966900, 3'd4};
				"y":  g = '{28'h0997160, 3'd4};
				"z":  g = '{28'h0F24F00, 3'd4};
				default: g = '{'0, '0};
			endcase
		end
		return g;
	endfunction

	// One glyph row as an 8-bit vector, the leftmost column in the highest used bit.
	function automatic logic [7:0] font_row(input glyph_t g, input int unsigned r);
		logic [7:0] v;
		v = '0;
		if (r < FONT_ROWS) begin
			v = {4'b0000, g.rows[(FONT_ROWS-1-r)*FONT_COLS +: FONT_COLS]};
		end
		return v;
	endfunction

endpackage

FILE: hdl/bgtp_if.sv
// Handshake channel interfaces of the glyph plotter: character input, pixel output, register write.
`timescale 1ns / 1ps

interface bgtp_char_if
	import bgtp_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [CHAR_W-1:0]          char_code;
	logic                       string_start;
	logic signed [POS_W-1:0]    start_x;
	logic signed [POS_W-1:0]    start_y;
	logic [COLOUR_W-1:0]        red;
	logic [COLOUR_W-1:0]        green;
	logic [COLOUR_W-1:0]        blue;

	modport source (output valid, char_code, string_start, start_x, start_y, red, green, blue,
		input ready);
	modport sink (input valid, char_code, string_start, start_x, start_y, red, green, blue,
		output ready);
endinterface

interface bgtp_pix_if
	import bgtp_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [OFFSET_W-1:0]   pixel_offset;
	logic [COLOUR_W-1:0]   out_blue;
	logic [COLOUR_W-1:0]   out_green;
	logic [COLOUR_W-1:0]   out_red;
	logic                  last_pixel;

	modport source (output valid, pixel_offset, out_blue, out_green, out_red, last_pixel,
		input ready);
	modport sink (input valid, pixel_offset, out_blue, out_green, out_red, last_pixel,
		output ready);
endinterface

interface bgtp_cfg_if
	import bgtp_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [DIM_REG_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/bitmap_glyph_text_plotter_core.sv
// Top level of the bitmap glyph text plotter: microcoded sequencer and its datapath.
`timescale 1ns / 1ps

// The plotter takes one character word and writes its glyph into a column-rotated BGR
// framebuffer, one pixel word per set glyph bit that lands inside the frame, the last one
// flagged. A character is accepted in the wait step, followed by two set-up steps (glyph
// fetch with clipping masks, then base address) and a scan of the glyph cell at one cell per
// cycle while the pixel output can take each drawn pixel; the scan ends at the last drawn
// pixel. The single pixel output register lets the next character be accepted while
// the final pixel of the previous one still waits. Register writes are taken on any
// cycle; values above FRAME_DIM_MAX are stored as FRAME_DIM_MAX.
module bitmap_glyph_text_plotter_core
	import bgtp_pkg::*;
#(
	parameter int unsigned FRAME_DIM_MAX = FRAME_DIM_MAX_DEF,
	parameter int unsigned GLYPH_ROWS    = GLYPH_ROWS_DEF,
	parameter int unsigned GLYPH_COLS    = GLYPH_COLS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bgtp_char_if.sink    chars,
	bgtp_pix_if.source   pixels,
	bgtp_cfg_if.sink     cfg
);

	localparam int unsigned DIM_FIT = $clog2(FRAME_DIM_MAX + 1);
	localparam int unsigned DIM_W   = (DIM_FIT > DIM_REG_W) ? DIM_FIT : DIM_REG_W;
	localparam int unsigned CMP_W   = (DIM_W + 1 > CURSOR_W + 2) ? DIM_W + 1 : CURSOR_W + 2;
	localparam int unsigned CELLS   = GLYPH_ROWS * GLYPH_COLS;
	localparam int unsigned COL_W   = $clog2(GLYPH_COLS);

	// Sequencer step addresses
	localparam logic [1:0] STEP_WAIT  = 2'd0;
	localparam logic [1:0] STEP_FETCH = 2'd1;
	localparam logic [1:0] STEP_BASE  = 2'd2;
	localparam logic [1:0] STEP_SCAN  = 2'd3;

	typedef enum logic [1:0] {
		C_NEVER,
		C_TAKEN,
		C_DONE
	} cond_t;

	typedef struct packed {
		cond_t      cond;
		logic [1:0] target;
		logic       stay;
		logic       take_in;
		logic       fetch;
		logic       base;
		logic       scan;
	} uword_t;

	// Control store: one word per step
	localparam uword_t UCODE [0:3] = '{
		'{cond: C_TAKEN, target: STEP_FETCH, stay: 1'b1, take_in: 1'b1, fetch: 1'b0,
			base: 1'b0, scan: 1'b0},
		'{cond: C_NEVER, target: STEP_WAIT, stay: 1'b0, take_in: 1'b0, fetch: 1'b1,
			base: 1'b0, scan: 1'b0},
		'{cond: C_NEVER, target: STEP_WAIT, stay: 1'b0, take_in: 1'b0, fetch: 1'b0,
			base: 1'b1, scan: 1'b0},
		'{cond: C_DONE, target: STEP_WAIT, stay: 1'b1, take_in: 1'b0, fetch: 1'b0,
			base: 1'b0, scan: 1'b1}
	};

	logic [1:0]                  pc_q;
	uword_t                      uw;
	logic [DIM_W-1:0]            frame_w_q;
	logic [DIM_W-1:0]            frame_h_q;
	logic [DIM_W-1:0]            cfg_dim;
	logic signed [CURSOR_W-1:0]  cursor_q;
	logic [CHAR_W-1:0]           code_q;
	logic signed [POS_W-1:0]     sy_q;
	logic [COLOUR_W-1:0]         red_q;
	logic [COLOUR_W-1:0]         green_q;
	logic [COLOUR_W-1:0]         blue_q;
	logic [ADV_W-1:0]            adv_q;
	logic [CELLS-1:0]            mask_q;
	logic [COL_W-1:0]            col_q;
	logic [OFFSET_W-1:0]         prod_q;
	logic [OFFSET_W-1:0]         h3_q;
	logic [OFFSET_W-1:0]         rowstep_q;
	logic [OFFSET_W-1:0]         off_q;
	logic                        out_valid_q;
	logic [OFFSET_W-1:0]         out_offset_q;
	logic [COLOUR_W-1:0]         out_blue_q;
	logic [COLOUR_W-1:0]         out_green_q;
	logic [COLOUR_W-1:0]         out_red_q;
	logic                        out_last_q;

	glyph_t                      glyph;
	logic [CELLS-1:0]            kept;
	logic [OFFSET_W-1:0]         cx_ext;
	logic [OFFSET_W-1:0]         h_ext;
	logic [OFFSET_W-1:0]         sy_ext;
	logic [OFFSET_W-1:0]         base_sum;
	logic [CURSOR_W:0]           cursor_next;
	logic                        taken;
	logic                        out_free;
	logic                        emit;
	logic                        advance;
	logic                        rest_empty;
	logic                        done;
	logic                        cond_hit;

	assign uw = UCODE[pc_q];

	// Handshakes and scan-step control
	assign chars.ready = uw.take_in;
	assign cfg.ready   = 1'b1;
	assign taken       = chars.valid & uw.take_in;
	assign out_free    = ~out_valid_q | pixels.ready;
	assign rest_empty  = (mask_q[CELLS-1:1] == '0);
	assign emit        = uw.scan & mask_q[0] & out_free;
	assign advance     = uw.scan & (~mask_q[0] | out_free);
	assign done        = advance & rest_empty;

	always_comb begin
		unique case (uw.cond)
			C_NEVER: cond_hit = 1'b0;
			C_TAKEN: cond_hit = taken;
			C_DONE:  cond_hit = done;
			default: cond_hit = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (cond_hit) begin
			pc_q <= uw.target;
		end else if (!uw.stay) begin
			pc_q <= pc_q + 2'd1;
		end
	end

	// Register writes, clamped to the largest supported frame dimension
	assign cfg_dim = (DIM_W'(cfg.data) > DIM_W'(FRAME_DIM_MAX)) ?
		DIM_W'(FRAME_DIM_MAX) : DIM_W'(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= DIM_W'(FRAME_W_RESET);
			frame_h_q <= DIM_W'(FRAME_H_RESET);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH:  frame_w_q <= cfg_dim;
				REG_FRAME_HEIGHT: frame_h_q <= cfg_dim;
				default: ;
			endcase
		end
	end

	// Glyph fetch and clipping: one row mask and one column mask, combined per cell.
	always_comb begin
		logic [7:0]               rb;
		logic signed [CMP_W-1:0]  px;
		logic signed [CMP_W-1:0]  py;
		logic [GLYPH_COLS-1:0]    col_ok;
		logic [GLYPH_ROWS-1:0]    row_ok;
		glyph = font_glyph(code_q);
		for (int c = 0; c < GLYPH_COLS; c++) begin
			px = $signed({{(CMP_W-CURSOR_W){cursor_q[CURSOR_W-1]}}, cursor_q}) +
				$signed(CMP_W'(c));
			col_ok[c] = ~px[CMP_W-1] &
				(px < $signed({{(CMP_W-DIM_W){1'b0}}, frame_w_q}));
		end
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			py = $signed({{(CMP_W-POS_W){sy_q[POS_W-1]}}, sy_q}) + $signed(CMP_W'(r));
			row_ok[r] = ~py[CMP_W-1] &
				(py < $signed({{(CMP_W-DIM_W){1'b0}}, frame_h_q}));
		end
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			rb = font_row(glyph, r);
			for (int c = 0; c < GLYPH_COLS; c++) begin
				kept[r*GLYPH_COLS + c] = rb[GLYPH_COLS-1-c] & col_ok[c] & row_ok[r];
			end
		end
	end

	// Address arithmetic is kept modulo the offset width, which is all the output shows.
	assign cx_ext   = {{(OFFSET_W-CURSOR_W){cursor_q[CURSOR_W-1]}}, cursor_q};
	assign h_ext    = {{(OFFSET_W-DIM_W){1'b0}}, frame_h_q};
	assign sy_ext   = {{(OFFSET_W-POS_W){sy_q[POS_W-1]}}, sy_q};
	assign base_sum = prod_q + h_ext - OFFSET_W'(1) - sy_ext;

	// Cursor advance by width plus one, saturating at the largest positive column
	assign cursor_next = {cursor_q[CURSOR_W-1], cursor_q} + (CURSOR_W+1)'(adv_q) +
		(CURSOR_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (taken && chars.string_start) begin
			cursor_q <= {{(CURSOR_W-POS_W){chars.start_x[POS_W-1]}}, chars.start_x};
		end else if (uw.base) begin
			if (!cursor_next[CURSOR_W] && cursor_next[CURSOR_W-1]) begin
				cursor_q <= {1'b0, {(CURSOR_W-1){1'b1}}};
			end else begin
				cursor_q <= cursor_next[CURSOR_W-1:0];
			end
		end
	end

	// Datapath registers loaded by the set-up steps and walked by the scan step
	always_ff @(posedge clk) begin
		if (taken) begin
			code_q  <= (chars.char_code > ASCII_MAX) ? QMARK_CODE : chars.char_code;
			sy_q    <= chars.start_y;
			red_q   <= chars.red;
			green_q <= chars.green;
			blue_q  <= chars.blue;
		end
		if (uw.fetch) begin
			adv_q  <= glyph.adv;
			mask_q <= kept;
			prod_q <= cx_ext * h_ext;
			h3_q   <= (h_ext << 1) + h_ext;
		end
		if (uw.base) begin
			off_q     <= (base_sum << 1) + base_sum;
			rowstep_q <= OFFSET_W'(0) - (h3_q * OFFSET_W'(GLYPH_COLS - 1)) - OFFSET_W'(3);
			col_q     <= '0;
		end
		if (advance) begin
			mask_q <= mask_q >> 1;
			if (col_q == COL_W'(GLYPH_COLS - 1)) begin
				col_q <= '0;
				off_q <= off_q + rowstep_q;
			end else begin
				col_q <= col_q + COL_W'(1);
				off_q <= off_q + h3_q;
			end
		end
		if (emit) begin
			out_offset_q <= off_q;
			out_blue_q   <= blue_q;
			out_green_q  <= green_q;
			out_red_q    <= red_q;
			out_last_q   <= rest_empty;
		end
	end

	// Pixel word output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pixels.valid        = out_valid_q;
	assign pixels.pixel_offset = out_offset_q;
	assign pixels.out_blue     = out_blue_q;
	assign pixels.out_green    = out_green_q;
	assign pixels.out_red      = out_red_q;
	assign pixels.last_pixel   = out_last_q;

endmodule

FILE: hdl/bgtp_checker.sv
// Port-level checks of the glyph plotter and the bind that attaches them to the top level.
`timescale 1ns / 1ps

module bgtp_checker
	import bgtp_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 chr_valid,
	input logic                 chr_ready,
	input logic                 pix_valid,
	input logic                 pix_ready,
	input logic [OFFSET_W-1:0]  pix_offset,
	input logic                 pix_last
);

	// A stalled pixel word keeps its offset and flag.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_offset) && $stable(pix_last))
		else $error("pixel word changed while stalled");

	// Only one character is in work at a time.
	a_one_char: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_ready |=> !chr_ready)
		else $error("character input ready straight after an accepted word");

	// A pending pixel that is not the last of its character means the scan is still running.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_last |-> !chr_ready)
		else $error("next character offered before the current one finished");

endmodule

bind bitmap_glyph_text_plotter_core bgtp_checker u_bgtp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.chr_valid  (chars.valid),
	.chr_ready  (chars.ready),
	.pix_valid  (pixels.valid),
	.pix_ready  (pixels.ready),
	.pix_offset (pixels.pixel_offset),
	.pix_last   (pixels.last_pixel)
);

FILE: bench/tb_bitmap_glyph_text_plotter_core.sv
// Self-checking bench for the glyph plotter: drives character words and checks every pixel word.
`timescale 1ns / 1ps

module tb_bitmap_glyph_text_plotter_core
	import bgtp_pkg::*;
();

	localparam int CLK_PERIOD   = 4;
	localparam int DRAIN_CYCLES = 48;
	localparam int RUN_LIMIT_NS = 15_000_000;
	localparam int CURSOR_MAX   = 32767;

	// Indexes past the register list; writes there must leave the frame untouched.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		logic [CHAR_W-1:0]       code;
		logic                    start;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [COLOUR_W-1:0]     red;
		logic [COLOUR_W-1:0]     green;
		logic [COLOUR_W-1:0]     blue;
	} char_word_t;

	typedef struct {
		logic [OFFSET_W-1:0] offset;
		logic [COLOUR_W-1:0] blue;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] red;
		logic                last;
	} pixel_word_t;

	// Keeps the frame size and pen column, and the pixel words still owed by the plotter.
	class glyph_scoreboard;
		int frame_w;
		int frame_h;
		logic signed [CURSOR_W-1:0] cursor;
		pixel_word_t expected_pixels[$];
		int mismatches;

		function new();
			frame_w = FRAME_W_RESET;
			frame_h = FRAME_H_RESET;
			cursor = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		task report(input string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		function int clamp_dim(input logic [DIM_REG_W-1:0] v);
			return (v > FRAME_DIM_MAX_DEF) ? FRAME_DIM_MAX_DEF : int'(v);
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_REG_W-1:0] v);
			case (idx)
				REG_FRAME_WIDTH: begin
					frame_w = clamp_dim(v);
				end
				REG_FRAME_HEIGHT: begin
					frame_h = clamp_dim(v);
				end
				default: begin
				end
			endcase
		endfunction

		// Font as one word per glyph: seven row nibbles from the top, then the advance.
		function logic [31:0] glyph_word(input logic [CHAR_W-1:0] code);
			case (code)
				" ":  return 32'h00000003;
				"!":  return 32'h44440404;
				"\"": return 32'hAA000004;
				"#":  return 32'hAFAFA004;
				"%":  return 32'h92490004;
				"(":  return 32'h24442003;
				")":  return 32'h42224003;
				"+":  return 32'h04E40004;
				",":  return 32'h00004484;
				"-":  return 32'h00E00004;
				".":  return 32'h00004004;
				"/":  return 32'h12480004;
				"0":  return 32'h69996004;
				"1":  return 32'h26227004;
				"2":  return 32'h6924F004;
				"3":  return 32'h69296004;
				"4":  return 32'h99F11004;
				"5":  return 32'hF8E1E004;
				"6":  return 32'h68E96004;
				"7":  return 32'hF1244004;
				"8":  return 32'h69696004;
				"9":  return 32'h69716004;
				":":  return 32'h04040004;
				"A":  return 32'h69F99004;
				"B":  return 32'hE9E9E004;
				"C":  return 32'h69896004;
				"D":  return 32'hE999E004;
				"E":  return 32'hF8E8F004;
				"F":  return 32'hF8E88004;
				"G":  return 32'h78B97004;
				"H":  return 32'h99F99004;
				"I":  return 32'hE444E004;
				"J":  return 32'h11196004;
				"K":  return 32'h9ACA9004;
				"L":  return 32'h8888F004;
				"M":  return 32'h9FF99004;
				"N":  return 32'h9DB99004;
				"O":  return 32'h69996004;
				"P":  return 32'hE9E88004;
				"Q":  return 32'h699B7004;
				"R":  return 32'hE9EA9004;
				"S":  return 32'h7861E004;
				"T":  return 32'hE4444004;
				"U":  return 32'h99996004;
				"V":  return 32'h99966004;
				"W":  return 32'h99FF9004;
				"X":  return 32'h99699004;
				"Y":  return 32'h99716004;
				"Z":  return 32'hF248F004;
				"a":  return 32'h06997004;
				"b":  return 32'h8E99E004;
				"c":  return 32'h07887004;
				"d":  return 32'h17997004;
				"e":  return 32'h06F87004;
				"f":  return 32'h34E44004;
				"g":  return 32'h07971604;
				"h":  return 32'h8E999004;
				"i":  return 32'h40444004;
				"j":  return 32'h2022A404;
				"k":  return 32'h8ACA9004;
				"l":  return 32'h44442004;
				"m":  return 32'h0FF99004;
				"n":  return 32'h0E999004;
				"o":  return 32'h06996004;
				"p":  return 32'h0E9E8804;
				"q":  return 32'h07971104;
				"r":  return 32'h0BC88004;
				"s":  return 32'h07C3E004;
				"t":  return 32'h4E443004;
				"u":  return 32'h09997004;
				"v":  return 32'h09966004;
				"w":  return 32'h09FF9004;
				"x":  return 32'h09669004;
				"y":  return 32'h09971604;
				"z":  return 32'h0F24F004;
				default: return 32'h0;
			endcase
		endfunction

		// Works out the pixel words of one accepted character and moves the pen on.
		function void plot_char(input char_word_t c);
			logic [CHAR_W-1:0] code;
			logic [31:0] g;
			logic [0:6][3:0] rows;
			int adv;
			int cx;
			int sy;
			int px;
			int py;
			int nx;
			int off;
			pixel_word_t w;
			pixel_word_t drawn[$];
			if (c.start) begin
				cursor = {{(CURSOR_W-POS_W){c.x[POS_W-1]}}, c.x};
			end
			cx = cursor;
			sy = c.y;
			code = c.code;
			if (code > ASCII_MAX) begin
				code = QMARK_CODE;
			end
			if (code < CTRL_LIMIT) begin
				rows = '0;
				adv = CTRL_ADV;
			end else begin
				g = glyph_word(code);
				rows = g[31:4];
				adv = g[3:0];
			end
			for (int row = 0; row < FONT_ROWS; row++) begin
				for (int col = 0; col < FONT_COLS; col++) begin
					px = cx + col;
					py = sy + row;
					if (rows[row][FONT_COLS-1-col] && px >= 0 && py >= 0 &&
						px < frame_w && py < frame_h) begin
						off = (px * frame_h + (frame_h - 1 - py)) * 3;
						w.offset = off[OFFSET_W-1:0];
						w.blue = c.blue;
						w.green = c.green;
						w.red = c.red;
						w.last = 1'b0;
						drawn.push_back(w);
					end
				end
			end
			if (drawn.size() > 0) begin
				drawn[drawn.size()-1].last = 1'b1;
			end
			foreach (drawn[i]) begin
				expected_pixels.push_back(drawn[i]);
			end
			// The pen saturates at the top of its signed range.
			nx = cx + adv + 1;
			if (nx > CURSOR_MAX) begin
				nx = CURSOR_MAX;
			end
			cursor = nx[CURSOR_W-1:0];
		endfunction

		task check_pixel(input pixel_word_t got);
			pixel_word_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected pixel word at offset %0d", got.offset));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.offset !== want.offset) begin
				report($sformatf("pixel offset %0d, wanted %0d", got.offset, want.offset));
			end
			if (got.blue !== want.blue) begin
				report($sformatf("blue %0h, wanted %0h", got.blue, want.blue));
			end
			if (got.green !== want.green) begin
				report($sformatf("green %0h, wanted %0h", got.green, want.green));
			end
			if (got.red !== want.red) begin
				report($sformatf("red %0h, wanted %0h", got.red, want.red));
			end
			if (got.last !== want.last) begin
				report($sformatf("last flag %0b, wanted %0b at offset %0d",
					got.last, want.last, want.offset));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit sender_calm = 1'b0;
	bit sink_calm = 1'b0;
	glyph_scoreboard sb;

	bgtp_char_if chars_if ();
	bgtp_pix_if pix_if ();
	bgtp_cfg_if cfg_if ();

	bitmap_glyph_text_plotter_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.pixels (pix_if),
		.cfg    (cfg_if)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// Mostly drawable glyphs, with undefined, control and high codes mixed in.
	function automatic int pick_code();
		string glyph_set = " !\"#%()+,-./0123456789:ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
		end else if (r < 78) begin
			return $urandom_range(32, 127);
		end else if (r < 89) begin
			return $urandom_range(0, 31);
		end
		return $urandom_range(128, 255);
	endfunction

	function automatic char_word_t mk_char(input int code, input bit start, input int x,
		input int y, input int r, input int g, input int b);
		char_word_t c;
		c.code = code[CHAR_W-1:0];
		c.start = start;
		c.x = x[POS_W-1:0];
		c.y = y[POS_W-1:0];
		c.red = r[COLOUR_W-1:0];
		c.green = g[COLOUR_W-1:0];
		c.blue = b[COLOUR_W-1:0];
		return c;
	endfunction

	// Offers one character word and notes it once it has been taken.
	task automatic send_char(input char_word_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_code <= c.code;
		chars_if.string_start <= c.start;
		chars_if.start_x <= c.x;
		chars_if.start_y <= c.y;
		chars_if.red <= c.red;
		chars_if.green <= c.green;
		chars_if.blue <= c.blue;
		do @(posedge clk); while (!chars_if.ready);
		sb.plot_char(c);
	endtask

	// Leaves the register valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value[DIM_REG_W-1:0];
		do @(posedge clk); while (!cfg_if.ready);
		sb.set_register(idx, value[DIM_REG_W-1:0]);
	endtask

	// Waits until every pixel word has arrived and a blank glyph scan would be over.
	task automatic wait_frame_idle();
		chars_if.valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Strings of random length near the frame, with some broken starts and stray rows.
	task automatic run_strings(input int n_items);
		int sent;
		int len;
		int x;
		int y;
		int r;
		int g;
		int b;
		bit broken;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 19) == 0) begin
				chars_if.valid <= 1'b0;
				do @(posedge clk); while (sb.pending() > 0);
			end
			len = $urandom_range(1, 8);
			if (len > n_items - sent) begin
				len = n_items - sent;
			end
			if ($urandom_range(0, 6) == 0) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = int'($urandom_range(0, sb.frame_w + 12)) - 8;
				y = int'($urandom_range(0, sb.frame_h + 12)) - 8;
			end
			broken = ($urandom_range(0, 9) == 0);
			r = $urandom;
			g = $urandom;
			b = $urandom;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					r = $urandom;
					g = $urandom;
					b = $urandom;
				end
				send_char(mk_char(pick_code(), (i == 0) && !broken,
					(i == 0) ? x : int'($urandom),
					($urandom_range(0, 9) == 0) ? int'($urandom) : y, r, g, b));
			end
			sent += len;
		end
	endtask

	// Pixel sink with random back-pressure, mostly short stalls and a few long ones.
	initial begin
		int hold;
		int r;
		hold = 0;
		pix_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_calm) begin
				pix_if.ready <= 1'b1;
			end else if (hold > 0) begin
				pix_if.ready <= 1'b0;
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					pix_if.ready <= 1'b1;
				end else begin
					pix_if.ready <= 1'b0;
					hold = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	// Every pixel word taken by the sink goes to the scoreboard.
	always @(posedge clk) begin : pixel_monitor
		pixel_word_t seen;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			seen.offset = pix_if.pixel_offset;
			seen.blue = pix_if.out_blue;
			seen.green = pix_if.out_green;
			seen.red = pix_if.out_red;
			seen.last = pix_if.last_pixel;
			sb.check_pixel(seen);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("bitmap_glyph_text_plotter_core verification failed");
		$finish;
	end

	initial begin
		int setting_w [6] = '{1, 1024, 2047, 0, 37, 400};
		int setting_h [6] = '{1, 1024, 1100, 77, 19, 240};
		sb = new();
		chars_if.valid <= 1'b0;
		chars_if.char_code <= '0;
		chars_if.string_start <= 1'b0;
		chars_if.start_x <= '0;
		chars_if.start_y <= '0;
		chars_if.red <= '0;
		chars_if.green <= '0;
		chars_if.blue <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_FRAME_WIDTH;
		cfg_if.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset frame size of 400 by 240.
		send_char(mk_char("A", 1, 0, 0, 8'h00, 8'h00, 8'h00));
		send_char(mk_char("B", 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
		send_char(mk_char("#", 0, 2047, 0, 8'h12, 8'h34, 8'h56));
		send_char(mk_char(1, 0, 0, 0, 8'hA5, 8'h5A, 8'hC3));
		send_char(mk_char(0, 0, 0, 0, 8'h01, 8'h02, 8'h03));
		send_char(mk_char(128, 0, 0, 0, 8'h80, 8'h40, 8'h20));
		send_char(mk_char(255, 0, 0, 0, 8'h7F, 8'hBF, 8'hDF));
		send_char(mk_char("$", 0, 0, 0, 8'h11, 8'h22, 8'h33));
		send_char(mk_char(127, 0, 0, 0, 8'h44, 8'h55, 8'h66));
		send_char(mk_char(" ", 0, 0, 0, 8'h77, 8'h88, 8'h99));
		send_char(mk_char("j", 0, 0, 0, 8'hAA, 8'hBB, 8'hCC));
		send_char(mk_char(",", 0, 0, 0, 8'hDD, 8'hEE, 8'hFF));
		send_char(mk_char("g", 0, 0, 1, 8'hFE, 8'hFD, 8'hFB));
		// Glyphs cut by each edge of the frame, and ones far outside it.
		send_char(mk_char("W", 1, -2, 100, 8'hF7, 8'hEF, 8'hDF));
		send_char(mk_char("M", 1, 398, 50, 8'hBF, 8'h7F, 8'h00));
		send_char(mk_char("H", 1, 100, -3, 8'h0F, 8'hF0, 8'h3C));
		send_char(mk_char("E", 1, 200, 236, 8'hC3, 8'h0F, 8'hF0));
		send_char(mk_char("8", 1, 396, 233, 8'h10, 8'h20, 8'h40));
		send_char(mk_char("g", 1, -2048, -2048, 8'h08, 8'h04, 8'h02));
		send_char(mk_char("Q", 1, 2047, 2047, 8'h99, 8'h66, 8'h33));
		send_char(mk_char("z", 1, -4, 5, 8'h5A, 8'hA5, 8'h3C));
		send_char(mk_char("a", 0, -2048, 5, 8'hE1, 8'h1E, 8'h87));

		// Random strings under a run of frame sizes, the extremes among them.
		for (int p = 0; p < 6; p++) begin
			wait_frame_idle();
			if (p == 4) begin
				write_reg(REG_SPARE_2, $urandom);
				write_reg(REG_SPARE_3, $urandom);
			end
			write_reg(REG_FRAME_WIDTH, setting_w[p]);
			write_reg(REG_FRAME_HEIGHT, setting_h[p]);
			cfg_if.valid <= 1'b0;
			sender_calm = (p == 1);
			sink_calm = (p == 1);
			run_strings(31);
		end

		// A fresh string once the frame runs are over.
		wait_frame_idle();
		sender_calm = 1'b0;
		sink_calm = 1'b0;
		send_char(mk_char("A", 1, 5, 5, 8'h12, 8'h34, 8'h56));

		wait_frame_idle();
		if (sb.mismatches == 0) begin
			$display("bitmap_glyph_text_plotter_core verification clean");
		end else begin
			$display("bitmap_glyph_text_plotter_core verification failed");
		end
		$finish;
	end

endmodule
